// File: hdl/sha512_pkg.sv
// Package for the SHA-512 hash engine: round constants, initial hash values
// and a rotate function. No dependencies.
`default_nettype none
package sha512_pkg;
  localparam int unsigned Rounds = 80;
  localparam int unsigned BlockBytes = 128;
  localparam int unsigned LenBound = 112;

  typedef logic [63:0] word_t;

  typedef struct packed {
    logic load_byte;
    logic pad;
    logic init_work;
    logic round_en;
    logic fold;
    logic clear_low;
    logic set_len;
    logic reload;
    logic clear_len;
    logic [6:0] round;
    logic [2:0] out_sel;
  } cmd_t;

  function automatic word_t round_k(input logic [6:0] r);
    word_t k;
    case (r)
      7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 64'h6a09e667f3bcc908; 3'd1: h = 64'hbb67ae8584caa73b;
      3'd2: h = 64'h3c6ef372fe94f82b; 3'd3: h = 64'ha54ff53a5f1d36f1;
      3'd4: h = 64'h510e527fade682d1; 3'd5: h = 64'h9b05688c2b3e6c1f;
      3'd6: h = 64'h1f83d9abfb41bd6b; default: h = 64'h5be0cd19137e2179;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction
endpackage
`default_nettype wire

// File: hdl/sha512_datapath.sv
// Datapath of the SHA-512 engine: block buffer, schedule, working words,
// hash words and length counter. Depends on sha512_pkg.
`default_nettype none
module sha512_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sha512_pkg::cmd_t  cmd_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic [6:0]        pos_i,
  output sha512_pkg::word_t      digest_o
);
  sha512_pkg::word_t blk_q [16];
  sha512_pkg::word_t wrk_q [8];
  sha512_pkg::word_t hash_q [8];
  logic [63:0] len_q;
  sha512_pkg::word_t w_new, t1, t2, s0, s1, e, a, bval;
  logic [3:0] widx;

  assign bval = cmd_i.pad ? 64'h80 : {56'd0, byte_i};
  assign widx = pos_i[6:3];

  always_comb begin
    s1 = blk_q[14];
    s0 = blk_q[1];
    if (cmd_i.round < 7'd16) begin
      w_new = blk_q[0];
    end else begin
      w_new = (sha512_pkg::rotr(s1, 19) ^ sha512_pkg::rotr(s1, 61) ^ (s1 >> 6)) + blk_q[9]
            + (sha512_pkg::rotr(s0, 1) ^ sha512_pkg::rotr(s0, 8) ^ (s0 >> 7)) + blk_q[0];
    end
    e = wrk_q[4];
    a = wrk_q[0];
    t1 = wrk_q[7] + (sha512_pkg::rotr(e, 14) ^ sha512_pkg::rotr(e, 18)
       ^ sha512_pkg::rotr(e, 41)) + ((e & wrk_q[5]) ^ (~e & wrk_q[6]))
       + sha512_pkg::round_k(cmd_i.round) + w_new;
    t2 = (sha512_pkg::rotr(a, 28) ^ sha512_pkg::rotr(a, 34) ^ sha512_pkg::rotr(a, 39))
       + ((a & wrk_q[1]) ^ (a & wrk_q[2]) ^ (wrk_q[1] & wrk_q[2]));
  end

  // The block buffer shifts one word per round, so schedule taps stay fixed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte || cmd_i.pad) begin
      for (int j = 0; j < 16; j++) begin
        if (4'(j) == widx) begin
          if (pos_i[2:0] == 3'd0) begin
            blk_q[j] <= bval << (7'd56 - {1'b0, pos_i[2:0], 3'b000});
          end else begin
            blk_q[j] <= blk_q[j] | (bval << (7'd56 - {1'b0, pos_i[2:0], 3'b000}));
          end
        end else if (cmd_i.pad && 4'(j) > widx) begin
          blk_q[j] <= '0;
        end
      end
    end else if (cmd_i.round_en) begin
      for (int j = 0; j < 15; j++) blk_q[j] <= blk_q[j+1];
      blk_q[15] <= w_new;
    end else if (cmd_i.clear_low) begin
      for (int j = 0; j < 14; j++) blk_q[j] <= '0;
    end else if (cmd_i.set_len) begin
      blk_q[14] <= '0;
      blk_q[15] <= len_q;
    end
    if (cmd_i.init_work) begin
      for (int j = 0; j < 8; j++) wrk_q[j] <= hash_q[j];
    end else if (cmd_i.round_en) begin
      for (int j = 1; j < 8; j++) wrk_q[j] <= wrk_q[j-1];
      wrk_q[4] <= wrk_q[3] + t1;
      wrk_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 8; j++) hash_q[j] <= sha512_pkg::init_hash(3'(j));
      len_q <= '0;
    end else begin
      if (cmd_i.reload) begin
        for (int j = 0; j < 8; j++) hash_q[j] <= sha512_pkg::init_hash(3'(j));
      end else if (cmd_i.fold) begin
        for (int j = 0; j < 8; j++) hash_q[j] <= hash_q[j] + wrk_q[j];
      end
      if (cmd_i.clear_len) begin
        len_q <= '0;
      end else if (cmd_i.load_byte) begin
        len_q <= len_q + 64'd8;
      end
    end
  end

  assign digest_o = hash_q[cmd_i.out_sel];
endmodule
`default_nettype wire

// File: hdl/sha512_ctrl.sv
// Controller of the SHA-512 engine: byte intake, padding, round sequencing
// and digest output. Depends on sha512_pkg.
`default_nettype none
module sha512_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             present_i,
  input  wire logic             eom_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [2:0]            out_idx_o,
  output sha512_pkg::cmd_t      cmd_o,
  output logic [6:0]            pos_o
);
  typedef enum logic [2:0] {
    SIdle, SPad, SLen, SInit, SRound, SFold, SClear, SOut
  } state_e;

  state_e state_q, state_d;
  logic [6:0] pos_q, pos_d, round_q, round_d;
  logic final_q, final_d, second_q, second_d, eom_q, eom_d;
  logic [2:0] oidx_q, oidx_d;
  logic in_fire;

  assign in_ready_o = (state_q == SIdle);
  assign in_fire = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == SOut);
  assign out_idx_o = oidx_q;
  assign pos_o = pos_q;

  always_comb begin
    state_d = state_q; pos_d = pos_q; round_d = round_q;
    final_d = final_q; second_d = second_q; eom_d = eom_q; oidx_d = oidx_q;
    cmd_o = '0;
    cmd_o.round = round_q;
    cmd_o.out_sel = oidx_q;
    case (state_q)
      SIdle: begin
        if (in_fire) begin
          eom_d = eom_i;
          if (present_i) begin
            cmd_o.load_byte = 1'b1;
            pos_d = pos_q + 7'd1;
            if (pos_q == 7'd127) begin
              state_d = SInit;
            end else if (eom_i) begin
              state_d = SPad;
            end
          end else if (eom_i) begin
            state_d = SPad;
          end
        end
      end
      SPad: begin
        cmd_o.pad = 1'b1;
        if (pos_q >= 7'(sha512_pkg::LenBound)) begin
          second_d = 1'b1;
          state_d = SInit;
        end else begin
          state_d = SLen;
        end
      end
      SLen: begin
        cmd_o.set_len = 1'b1;
        final_d = 1'b1;
        state_d = SInit;
      end
      SInit: begin
        cmd_o.init_work = 1'b1;
        round_d = '0;
        state_d = SRound;
      end
      SRound: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 7'd1;
        if (round_q == 7'(sha512_pkg::Rounds - 1)) state_d = SFold;
      end
      SFold: begin
        cmd_o.fold = 1'b1;
        round_d = '0;
        pos_d = '0;
        if (final_q) begin
          state_d = SOut;
          oidx_d = '0;
        end else if (second_q) begin
          second_d = 1'b0;
          state_d = SClear;
        end else begin
          state_d = eom_q ? SPad : SIdle;
        end
      end
      SClear: begin
        cmd_o.clear_low = 1'b1;
        state_d = SLen;
      end
      SOut: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            cmd_o.reload = 1'b1;
            cmd_o.clear_len = 1'b1;
            eom_d = 1'b0;
            final_d = 1'b0;
            state_d = SIdle;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; pos_q <= '0; round_q <= '0; final_q <= 1'b0;
      second_q <= 1'b0; eom_q <= 1'b0; oidx_q <= '0;
    end else begin
      state_q <= state_d; pos_q <= pos_d; round_q <= round_d; final_q <= final_d;
      second_q <= second_d; eom_q <= eom_d; oidx_q <= oidx_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during output");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRound) |-> (round_q < 7'd80)) else $error("round overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(oidx_q)))
    else $error("output index moved while stalled");
endmodule
`default_nettype wire

// File: hdl/sha512_hash_engine_top.sv
// Top level of the SHA-512 hash engine: stream ports, controller and datapath.
// Depends on sha512_pkg, sha512_ctrl and sha512_datapath.
//
// Channel   Dir  Payload
// s_axis    in   tdata = data_byte[7:0]; tuser = {end_of_message, byte_present}
// m_axis    out  tdata = digest_word[63:0]; tuser = word_index[2:0]; tlast = last_word
//
// A byte item is taken only while idle; a full block then runs the 80 rounds
// of the single shared round unit between its load and fold steps.
// End of message adds a pad step and a length step before the last block;
// a pad byte at or past byte 112 first hashes that block and adds a clear step.
// Then eight digest words follow, each held until m_axis_tready.
// Reset is asynchronous and restores the initial hash values.
`default_nettype none
module sha512_hash_engine_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic [1:0]  s_axis_tuser,   // {end_of_message, byte_present}
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // digest_word
  output logic [2:0]       m_axis_tuser,   // word_index
  output logic             m_axis_tlast
);
  sha512_pkg::cmd_t cmd;
  logic [6:0] pos;

  sha512_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .present_i(s_axis_tuser[0]), .eom_i(s_axis_tuser[1]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_idx_o(m_axis_tuser), .cmd_o(cmd), .pos_o(pos)
  );

  sha512_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .byte_i(s_axis_tdata), .pos_i(pos),
    .digest_o(m_axis_tdata)
  );

  assign m_axis_tlast = (m_axis_tuser == 3'd7);
endmodule
`default_nettype wire

// File: test/sha512_hash_engine_top_test.sv
// Self-checking testbench for the SHA-512 hash engine top level.
// Depends on sha512_pkg and sha512_hash_engine_top; drives byte requests, checks digest words.
`timescale 1ns / 100ps
module sha512_hash_engine_top_test;
  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  sha512_hash_engine_top dut (.*);

  sha512_pkg::word_t chain[8];
  sha512_pkg::word_t blk[16];
  int      fill;
  logic [63:0] bit_count;
  digest_t digest_q[$];
  int      send_idle;
  int      recv_stall;
  int      errors;
  int      requests;
  int      messages;
  int      idle_cycles;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic sha512_pkg::word_t k_of(input int r);
    sha512_pkg::word_t t[80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    return t[r];
  endfunction

  function automatic sha512_pkg::word_t ror(input sha512_pkg::word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void load_iv();
    chain = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
              64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
              64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
  endfunction

  function automatic void compress();
    sha512_pkg::word_t w[16];
    sha512_pkg::word_t v[8];
    sha512_pkg::word_t s0, s1, t1, t2;
    int    j;
    w = blk;
    v = chain;
    for (int r = 0; r < 80; r++) begin
      j = r % 16;
      if (r >= 16) begin
        s1 = w[(j + 14) % 16];
        s0 = w[(j + 1) % 16];
        w[j] = (ror(s1, 19) ^ ror(s1, 61) ^ (s1 >> 6)) + w[(j + 9) % 16]
             + (ror(s0, 1) ^ ror(s0, 8) ^ (s0 >> 7)) + w[j];
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_of(r) + w[j];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function automatic void put_byte(input int pos, input logic [7:0] b);
    if (pos % 8 == 0) blk[pos / 8] = '0;
    blk[pos / 8][63 - 8 * (pos % 8) -: 8] = b;
  endfunction

  function automatic void predict_digest(input logic [7:0] b, input logic present,
                                         input logic eom);
    digest_t d;
    if (present) begin
      put_byte(fill, b);
      bit_count += 8;
      fill++;
      if (fill == 128) begin
        compress();
        fill = 0;
      end
    end
    if (!eom) return;
    put_byte(fill, 8'h80);
    for (int i = fill / 8 + 1; i < 16; i++) blk[i] = '0;
    if (fill >= 112) begin
      compress();
      for (int i = 0; i < 14; i++) blk[i] = '0;
    end
    blk[14] = '0;
    blk[15] = bit_count;
    compress();
    for (int i = 0; i < 8; i++) begin
      d.word = chain[i];
      d.index = 3'(i);
      d.last = (i == 7);
      digest_q.push_back(d);
    end
    load_iv();
    fill = 0;
    bit_count = '0;
    messages++;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_request(input logic [7:0] b, input logic present, input logic eom);
    while (send_idle > 0 && ($urandom_range(99) < send_idle)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= {eom, present};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_digest(b, present, eom);
    requests++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int len, input bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(7) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, (i == len - 1));
    end
    if (len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'ha5, 1'b1, 1'b1);
    send_request(8'h5a, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h3c, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_pad_bounds();
    send_message(112, 1'b0);
    send_message(128, 1'b0);
    drain();
  endtask

  task automatic test_random(input int sidle, input int rstall, input int budget);
    int n;
    int len;
    send_idle = sidle;
    recv_stall = rstall;
    n = 0;
    while (n < budget) begin
      case ($urandom_range(5))
        0: len = 0;
        default: len = int'($urandom_range(1, 12));
      endcase
      send_message(len, 1'($urandom_range(1)));
      n += len + 1;
    end
    drain();
  endtask

  initial begin
    errors = 0; requests = 0; messages = 0; send_idle = 0; recv_stall = 0;
    load_iv();
    fill = 0;
    bit_count = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pad_bounds();
    test_random(0, 0, 15);
    test_random(84, 0, 12);
    test_random(0, 84, 12);
    test_random(37, 37, 12);
    test_random(0, 0, 10);
    drain();
    repeat (200) @(posedge clk_i);
    $display("Sent %0d requests in %0d messages, covering empty, pad-boundary and random",
             requests, messages);
    $display("messages under sender idling and receiver stalls.");
    if (errors == 0 && digest_q.size() == 0) begin
      $display("** sha512_hash_engine_top: PASSED **");
    end else begin
      $display("** sha512_hash_engine_top: FAILED **");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, '0);
      end else begin
        if (m_axis_tdata !== digest_q[0].word)
          report_mismatch("digest_word", m_axis_tdata, digest_q[0].word);
        if (m_axis_tuser !== digest_q[0].index)
          report_mismatch("word_index", 64'(m_axis_tuser), 64'(digest_q[0].index));
        if (m_axis_tlast !== digest_q[0].last)
          report_mismatch("last_word", 64'(m_axis_tlast), 64'(digest_q[0].last));
        void'(digest_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired at %0t", $realtime);
      $display("** sha512_hash_engine_top: FAILED **");
      $finish;
    end
  end

  initial idle_cycles = 0;
endmodule

// File: sim.f
hdl/sha512_pkg.sv
hdl/sha512_datapath.sv
hdl/sha512_ctrl.sv
hdl/sha512_hash_engine_top.sv
test/sha512_hash_engine_top_test.sv
